>>> rtl/core/motor_command_frame_packer_assert.svh
// Assertion macros for the motor command frame packer.
`ifndef MOTOR_COMMAND_FRAME_PACKER_ASSERT_SVH
`define MOTOR_COMMAND_FRAME_PACKER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define MCFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in the next cycle follows from a condition now.
`define MCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/mcfp_pkg.sv
// Shared types, constants and arithmetic steps for the motor command frame packer.
package mcfp_pkg;

  localparam int NumLanes = 5;
  localparam int DivSteps = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam int LanePos   = 0;
  localparam int LaneVel   = 1;
  localparam int LaneStiff = 2;
  localparam int LaneDamp  = 3;
  localparam int LaneTorq  = 4;

  localparam logic [15:0] PosFull    = 16'hFFFF;
  localparam logic [15:0] NarrowFull = 16'h0FFF;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPosMin   = 3'd0,
    CfgPosMax   = 3'd1,
    CfgVelMin   = 3'd2,
    CfgVelMax   = 3'd3,
    CfgStiffMax = 3'd4,
    CfgDampMax  = 3'd5,
    CfgTorqMin  = 3'd6,
    CfgTorqMax  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] position_min;
    logic signed [31:0] position_max;
    logic signed [31:0] velocity_min;
    logic signed [31:0] velocity_max;
    logic        [30:0] stiffness_max;
    logic        [30:0] damping_max;
    logic signed [31:0] torque_min;
    logic signed [31:0] torque_max;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    position_min:  -32'sd6258688,
    position_max:  32'sd6258688,
    velocity_min:  -32'sd1966080,
    velocity_max:  32'sd1966080,
    stiffness_max: 31'd32768000,
    damping_max:   31'd327680,
    torque_min:    -32'sd1179648,
    torque_max:    32'sd1179648
  };

  typedef struct packed {
    logic signed [31:0] target_position;
    logic signed [31:0] target_velocity;
    logic signed [31:0] stiffness_gain;
    logic signed [31:0] damping_gain;
    logic signed [31:0] feedforward_torque;
  } in_t;

  typedef struct packed {
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [7:0] byte_4;
    logic [7:0] byte_5;
    logic [7:0] byte_6;
    logic [7:0] byte_7;
  } out_t;

  typedef struct packed {
    logic [31:0] span;
    logic [31:0] off;
  } scl_lane_t;

  typedef struct packed {
    logic [31:0] span;
    logic [47:0] acc;
  } div_lane_t;

  typedef scl_lane_t [NumLanes-1:0] scl_vec_t;
  typedef div_lane_t [NumLanes-1:0] div_vec_t;

  function automatic scl_lane_t clamp_offset(logic signed [32:0] x, logic signed [32:0] lo,
                                             logic signed [32:0] hi);
    scl_lane_t        r;
    logic signed [32:0] c;
    logic        [32:0] d_off;
    logic        [32:0] d_span;
    c = x;
    if (x < lo) c = lo;
    if (x > hi) c = hi;
    d_off  = c - lo;
    d_span = hi - lo;
    if (hi <= lo) begin
      r.span = 32'd1;
      r.off  = 32'd0;
    end else begin
      r.span = d_span[31:0];
      r.off  = d_off[31:0];
    end
    return r;
  endfunction

  function automatic div_lane_t div_step(div_lane_t l);
    div_lane_t   r;
    logic [32:0] t;
    logic [33:0] diff;
    logic        ge;
    t    = {l.acc[47:16], l.acc[15]};
    diff = {1'b0, t} - {2'b00, l.span};
    ge   = ~diff[33];
    r.span = l.span;
    r.acc  = {(ge ? diff[31:0] : t[31:0]), l.acc[14:0], ge};
    return r;
  endfunction

endpackage

>>> rtl/core/mcfp_cfg.sv
// Configuration register file for the motor command frame packer.
module mcfp_cfg import mcfp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgPosMin:   cfg_q.position_min  <= cfg_wdata_i;
        CfgPosMax:   cfg_q.position_max  <= cfg_wdata_i;
        CfgVelMin:   cfg_q.velocity_min  <= cfg_wdata_i;
        CfgVelMax:   cfg_q.velocity_max  <= cfg_wdata_i;
        CfgStiffMax: cfg_q.stiffness_max <= cfg_wdata_i[30:0];
        CfgDampMax:  cfg_q.damping_max   <= cfg_wdata_i[30:0];
        CfgTorqMin:  cfg_q.torque_min    <= cfg_wdata_i;
        CfgTorqMax:  cfg_q.torque_max    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/mcfp_front.sv
// Clamp, offset and full-scale product stages of the motor command frame packer.
module mcfp_front import mcfp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_t      in_data_i,
  input  cfg_t     cfg_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output div_vec_t out_lanes_o
);

  logic signed [32:0] x_in  [NumLanes];
  logic signed [32:0] lo_in [NumLanes];
  logic signed [32:0] hi_in [NumLanes];

  scl_vec_t s1_d, s1_q;
  div_vec_t s2_d, s2_q;
  logic     v1_q, v2_q;
  logic     rdy1, rdy2;

  always_comb begin
    x_in[LanePos]    = {in_data_i.target_position[31], in_data_i.target_position};
    x_in[LaneVel]    = {in_data_i.target_velocity[31], in_data_i.target_velocity};
    x_in[LaneStiff]  = {in_data_i.stiffness_gain[31], in_data_i.stiffness_gain};
    x_in[LaneDamp]   = {in_data_i.damping_gain[31], in_data_i.damping_gain};
    x_in[LaneTorq]   = {in_data_i.feedforward_torque[31], in_data_i.feedforward_torque};
    lo_in[LanePos]   = {cfg_i.position_min[31], cfg_i.position_min};
    lo_in[LaneVel]   = {cfg_i.velocity_min[31], cfg_i.velocity_min};
    lo_in[LaneStiff] = '0;
    lo_in[LaneDamp]  = '0;
    lo_in[LaneTorq]  = {cfg_i.torque_min[31], cfg_i.torque_min};
    hi_in[LanePos]   = {cfg_i.position_max[31], cfg_i.position_max};
    hi_in[LaneVel]   = {cfg_i.velocity_max[31], cfg_i.velocity_max};
    hi_in[LaneStiff] = {2'b00, cfg_i.stiffness_max};
    hi_in[LaneDamp]  = {2'b00, cfg_i.damping_max};
    hi_in[LaneTorq]  = {cfg_i.torque_max[31], cfg_i.torque_max};
  end

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    localparam logic [15:0] Full = (i == LanePos) ? PosFull : NarrowFull;
    logic [47:0] prod;
    assign s1_d[i]      = clamp_offset(x_in[i], lo_in[i], hi_in[i]);
    assign prod         = {16'd0, s1_q[i].off} * {32'd0, Full};
    assign s2_d[i].span = s1_q[i].span;
    assign s2_d[i].acc  = prod;
  end

  assign rdy2       = ~v2_q | out_ready_i;
  assign rdy1       = ~v1_q | rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q)       s2_q <= s2_d;
  end

  assign out_valid_o = v2_q;
  assign out_lanes_o = s2_q;

endmodule

>>> rtl/core/mcfp_div.sv
// Pipelined restoring divider, one quotient bit per stage, for all five lanes.
module mcfp_div import mcfp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  div_vec_t in_lanes_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output div_vec_t out_lanes_o
);

  logic [DivSteps-1:0] v_q;
  logic [DivSteps-1:0] rdy;
  div_vec_t            d_q [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_stage
    logic     v_in;
    div_vec_t src;
    div_vec_t nxt;

    if (k == 0) begin : g_first
      assign v_in = in_valid_i;
      assign src  = in_lanes_i;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign src  = d_q[k-1];
    end

    if (k == DivSteps - 1) begin : g_last
      assign rdy[k] = ~v_q[k] | out_ready_i;
    end else begin : g_mid
      assign rdy[k] = ~v_q[k] | rdy[k+1];
    end

    for (genvar i = 0; i < NumLanes; i++) begin : g_lane
      assign nxt[i] = div_step(src[i]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) d_q[k] <= nxt;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[DivSteps-1];
  assign out_lanes_o = d_q[DivSteps-1];

endmodule

>>> rtl/core/motor_command_frame_packer.sv
// Motor command frame packer: clamps and scales a five-value command into an 8-byte frame.
// Throughput: one command per cycle while out_stall_i is low;
// 2 clamp/product stages, 16 divider stages, 1 output stage.
// The 16-stage divider (one quotient bit per stage) sets the depth.
// Stalls close pipeline bubbles; input stalls only when every stage holds a command.
// Reset clears all valid bits and loads the default limits into the registers.
module motor_command_frame_packer import mcfp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  `include "motor_command_frame_packer_assert.svh"

  cfg_t     cfg;
  logic     front_ready;
  logic     front_valid;
  div_vec_t front_lanes;
  logic     div_ready;
  logic     div_valid;
  div_vec_t div_lanes;
  logic     out_ready;
  logic     out_valid_q;
  out_t     out_d, out_q;

  mcfp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  mcfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (front_ready),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .out_valid_o(front_valid),
    .out_ready_i(div_ready),
    .out_lanes_o(front_lanes)
  );

  mcfp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (front_valid),
    .in_ready_o (div_ready),
    .in_lanes_i (front_lanes),
    .out_valid_o(div_valid),
    .out_ready_i(out_ready),
    .out_lanes_o(div_lanes)
  );

  always_comb begin
    logic [15:0] p;
    logic [11:0] v, k, d, t;
    p = div_lanes[LanePos].acc[15:0];
    v = div_lanes[LaneVel].acc[11:0];
    k = div_lanes[LaneStiff].acc[11:0];
    d = div_lanes[LaneDamp].acc[11:0];
    t = div_lanes[LaneTorq].acc[11:0];
    out_d.byte_0 = p[15:8];
    out_d.byte_1 = p[7:0];
    out_d.byte_2 = v[11:4];
    out_d.byte_3 = {v[3:0], k[11:8]};
    out_d.byte_4 = k[7:0];
    out_d.byte_5 = d[11:4];
    out_d.byte_6 = {d[3:0], t[11:8]};
    out_d.byte_7 = t[7:0];
  end

  assign out_ready = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && div_valid) out_q <= out_d;
  end

  assign in_stall_o  = ~front_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MCFP_ASSERT(a_stall_from_output, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without output backpressure")
  `MCFP_ASSERT(a_rem_below_span, div_valid |-> (div_lanes[LanePos].acc[47:16] < div_lanes[LanePos].span), "position remainder not below span")
  `MCFP_ASSERT(a_narrow_codes_fit, div_valid |-> (div_lanes[LaneVel].acc[15:12] == 4'd0 && div_lanes[LaneStiff].acc[15:12] == 4'd0 && div_lanes[LaneDamp].acc[15:12] == 4'd0 && div_lanes[LaneTorq].acc[15:12] == 4'd0), "narrow code exceeds 12 bits")
  `MCFP_ASSERT_NEXT(a_drain_empties, out_valid_o && !out_stall_i && !div_valid, !out_valid_o, "output stays valid after its transfer with nothing behind")

endmodule
